[rtl/otp_pkg.sv]
// Shared types and constants of the touch frame converter adapter.
package otp_pkg;

   // Beam geometry of the frame.
   localparam int TOTAL_BEAMS  = 64;
   localparam int ACROSS_BEAMS = 40;
   localparam int DOWN_BEAMS   = TOTAL_BEAMS - ACROSS_BEAMS;
   localparam int SCREEN_WIDTH = 640;
   localparam int HALF_ACROSS  = 8;
   localparam int HALF_DOWN    = 10;

   // Scaled tolerances of the exact hit compares.
   localparam int ACROSS_SCALE = 2 * ACROSS_BEAMS;
   localparam int ACROSS_SPAN  = 2 * HALF_ACROSS * ACROSS_BEAMS;
   localparam int DOWN_SCALE   = 2 * DOWN_BEAMS;
   localparam int DOWN_SPAN    = 2 * HALF_DOWN * DOWN_BEAMS;

   // Sample codes and read data constants.
   localparam logic [5:0] SAMPLE_CLEAR   = 6'h00;
   localparam logic [5:0] SAMPLE_DARK    = 6'h3f;
   localparam logic [5:0] SAMPLE_HIGH    = 6'h20;
   localparam logic [7:0] SELECT_NONE    = 8'hff;
   localparam logic [7:0] RECEIVER_RESET = 8'hff;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_LCD_TOP       = 2'd0,
      CSR_LCD_CONTENT   = 2'd1,
      CSR_CONVERT_TICKS = 2'd2
   } csr_index_type;

   // Request kinds; the fourth code means nothing.
   typedef enum logic [1:0] {
      REQ_READ  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_TICK  = 2'd2
   } req_kind_type;

   // Register offsets.
   typedef enum logic [1:0] {
      PORT_SELECT  = 2'd0,
      PORT_DIAG    = 2'd1,
      PORT_CONTROL = 2'd2,
      PORT_RESULT  = 2'd3
   } port_sel_type;

   // One request beat.
   typedef struct packed {
      req_kind_type req_type;
      port_sel_type port;
      logic [7:0]   wdata;
      logic         touch_present;
      logic [9:0]   touch_x;
      logic [8:0]   touch_y;
      logic         lcd_power_ok;
   } item_type;

   // Configuration register values.
   typedef struct packed {
      logic [8:0]  lcd_top;
      logic [8:0]  lcd_content;
      logic [15:0] convert_ticks;
   } cfg_type;

endpackage

[rtl/otp_beam.sv]
// Beam hit test: decides whether the contact blocks the receiver's beam.
module otp_beam (
   input  logic                 touch_present,
   input  logic [9:0]           touch_x,
   input  logic [8:0]           touch_y,
   input  logic [7:0]           receiver,
   input  otp_pkg::cfg_type     cfg,
   output logic                 blocked
);

   logic [6:0]  beam_idx;
   logic [7:0]  beam_odd;
   logic [6:0]  down_k;
   logic [7:0]  down_odd;
   logic [19:0] across_lhs;
   logic [19:0] across_ctr;
   logic        across_hit;
   logic [8:0]  py;
   logic        py_inside;
   logic [19:0] down_lhs;
   logic [19:0] down_ctr;
   logic        down_hit;

   // Beam index from the receiver latch: high nibble by eight plus low three bits.
   assign beam_idx = {receiver[7:4], receiver[2:0]};

   // Across beams: |2*A*x - (2k+1)*640| <= 16*A.
   assign beam_odd   = {beam_idx, 1'b1};
   assign across_lhs = 20'(touch_x) * 20'(otp_pkg::ACROSS_SCALE);
   assign across_ctr = 20'(beam_odd) * 20'(otp_pkg::SCREEN_WIDTH);
   assign across_hit = (across_lhs + 20'(otp_pkg::ACROSS_SPAN) >= across_ctr) &&
                       (across_lhs <= across_ctr + 20'(otp_pkg::ACROSS_SPAN));

   // Down beams: row must fall inside the content band, then the scaled compare.
   assign down_k    = beam_idx - 7'(otp_pkg::ACROSS_BEAMS);
   assign down_odd  = {down_k, 1'b1};
   assign py        = touch_y - cfg.lcd_top;
   assign py_inside = (touch_y >= cfg.lcd_top) && (py < cfg.lcd_content);
   assign down_lhs  = 20'(py) * 20'(otp_pkg::DOWN_SCALE);
   assign down_ctr  = 20'(down_odd) * 20'(cfg.lcd_content);
   assign down_hit  = py_inside &&
                      (down_lhs + 20'(otp_pkg::DOWN_SPAN) >= down_ctr) &&
                      (down_lhs <= down_ctr + 20'(otp_pkg::DOWN_SPAN));

   // Pick the beam group; indexes past the last beam never block.
   always_comb begin
      blocked = 1'b0;
      if (touch_present && ({1'b0, beam_idx} < 8'(otp_pkg::TOTAL_BEAMS))) begin
         if ({1'b0, beam_idx} < 8'(otp_pkg::ACROSS_BEAMS)) begin
            blocked = across_hit;
         end else begin
            blocked = down_hit;
         end
      end
   end

endmodule

[rtl/otp_regs.sv]
// Adapter latches and conversion countdown, with the read data of each beat.
module otp_regs (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  otp_pkg::item_type    item,
   input  otp_pkg::cfg_type     cfg,
   output logic [7:0]           rdata
);

   logic [7:0]  select_ff,   select_in;
   logic [3:0]  control_ff,  control_in;
   logic [7:0]  receiver_ff, receiver_in;
   logic        driver_ff,   driver_in;
   logic        ready_ff,    ready_in;
   logic [5:0]  held_ff,     held_in;
   logic [5:0]  result_ff,   result_in;
   logic [15:0] count_ff,    count_in;
   logic        active_ff,   active_in;

   logic        ctrl_write;
   logic [7:0]  receiver_eff;
   logic        driver_eff;
   logic        blocked;
   logic [5:0]  sample;

   // A control write samples with its own receiver copy and driver bit.
   assign ctrl_write   = (item.req_type == otp_pkg::REQ_WRITE) &&
                         (item.port == otp_pkg::PORT_CONTROL);
   assign receiver_eff = (ctrl_write && item.wdata[2]) ? select_ff : receiver_ff;
   assign driver_eff   = ctrl_write ? item.wdata[1] : driver_ff;

   otp_beam u_beam (
      .touch_present (item.touch_present),
      .touch_x       (item.touch_x),
      .touch_y       (item.touch_y),
      .receiver      (receiver_eff),
      .cfg           (cfg),
      .blocked       (blocked)
   );

   assign sample = (driver_eff && !blocked) ? otp_pkg::SAMPLE_CLEAR : otp_pkg::SAMPLE_DARK;

   // Next state and read data for the beat in the item register.
   always_comb begin
      select_in   = select_ff;
      control_in  = control_ff;
      receiver_in = receiver_ff;
      driver_in   = driver_ff;
      ready_in    = ready_ff;
      held_in     = held_ff;
      result_in   = result_ff;
      count_in    = count_ff;
      active_in   = active_ff;
      rdata       = 8'h00;
      unique case (item.req_type)
         otp_pkg::REQ_READ: begin
            unique case (item.port)
               otp_pkg::PORT_SELECT: begin
                  rdata = select_ff;
               end
               otp_pkg::PORT_DIAG: begin
                  rdata = {1'b0, select_ff != otp_pkg::SELECT_NONE, 3'b000,
                           sample >= otp_pkg::SAMPLE_HIGH, item.lcd_power_ok, 1'b1};
               end
               otp_pkg::PORT_CONTROL: begin
                  rdata = {4'h0, !ready_ff, control_ff[2:0]};
               end
               otp_pkg::PORT_RESULT: begin
                  rdata    = {2'b00, result_ff};
                  ready_in = 1'b0;
               end
               default: ;
            endcase
         end
         otp_pkg::REQ_WRITE: begin
            if (item.port == otp_pkg::PORT_SELECT) begin
               select_in = item.wdata;
            end else if (item.port == otp_pkg::PORT_CONTROL) begin
               control_in = item.wdata[3:0];
               if (item.wdata[2]) begin
                  receiver_in = select_ff;
               end
               driver_in = item.wdata[1];
               // Start bit high aborts; its falling edge samples and starts counting.
               if (item.wdata[3]) begin
                  active_in = 1'b0;
                  ready_in  = 1'b0;
               end else if (control_ff[3]) begin
                  ready_in  = 1'b0;
                  held_in   = sample;
                  count_in  = cfg.convert_ticks;
                  active_in = 1'b1;
               end
            end
         end
         otp_pkg::REQ_TICK: begin
            if (active_ff) begin
               if (count_ff <= 16'd1) begin
                  count_in  = 16'd0;
                  active_in = 1'b0;
                  result_in = held_ff;
                  ready_in  = 1'b1;
               end else begin
                  count_in = count_ff - 16'd1;
               end
            end
         end
         default: ;
      endcase
   end

   // State registers advance once per beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         select_ff   <= 8'h00;
         control_ff  <= 4'h0;
         receiver_ff <= otp_pkg::RECEIVER_RESET;
         driver_ff   <= 1'b0;
         ready_ff    <= 1'b0;
         held_ff     <= 6'h00;
         result_ff   <= 6'h00;
         count_ff    <= 16'd0;
         active_ff   <= 1'b0;
      end else if (fire) begin
         select_ff   <= select_in;
         control_ff  <= control_in;
         receiver_ff <= receiver_in;
         driver_ff   <= driver_in;
         ready_ff    <= ready_in;
         held_ff     <= held_in;
         result_ff   <= result_in;
         count_ff    <= count_in;
         active_ff   <= active_in;
      end
   end

endmodule

[rtl/optical_touch_panel_adc_adapter.sv]
// Top level of the touch frame converter adapter: channels, item and result registers.
//
//   channel   direction   beat carries
//   req_      in          one bus read, bus write or microsecond tick with touch state
//   rsp_      out         rdata for that beat
//   csr_      in          register index and write data
//
// Each beat passes through the item register and then the result register. The latch
// update sits between them, so one beat per cycle is sustained while rsp_ready is high.
// A new beat is taken while a result waits, as long as the result register drains.
// Synchronous reset clears the latches (receiver latch: all ones) and sets cfg defaults.
module optical_touch_panel_adc_adapter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [1:0]  req_port,
   input  logic [7:0]  req_wdata,
   input  logic        req_touch_present,
   input  logic [9:0]  req_touch_x,
   input  logic [8:0]  req_touch_y,
   input  logic        req_lcd_power_ok,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_rdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   otp_pkg::cfg_type  cfg_ff;
   otp_pkg::item_type item_ff;
   logic              item_valid_ff;
   logic              rsp_valid_ff;
   logic [7:0]        rsp_rdata_ff;
   logic              advance;
   logic              req_fire;
   logic [7:0]        rdata;

   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_rdata = rsp_rdata_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lcd_top       <= 9'd0;
         cfg_ff.lcd_content   <= 9'd480;
         cfg_ff.convert_ticks <= 16'd10;
      end else if (csr_valid && csr_ready) begin
         unique case (otp_pkg::csr_index_type'(csr_index))
            otp_pkg::CSR_LCD_TOP:       cfg_ff.lcd_top       <= csr_wdata[8:0];
            otp_pkg::CSR_LCD_CONTENT:   cfg_ff.lcd_content   <= csr_wdata[8:0];
            otp_pkg::CSR_CONVERT_TICKS: cfg_ff.convert_ticks <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Item register.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_fire) begin
         item_valid_ff <= 1'b1;
      end else if (advance) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.req_type      <= otp_pkg::req_kind_type'(req_type);
         item_ff.port          <= otp_pkg::port_sel_type'(req_port);
         item_ff.wdata         <= req_wdata;
         item_ff.touch_present <= req_touch_present;
         item_ff.touch_x       <= req_touch_x;
         item_ff.touch_y       <= req_touch_y;
         item_ff.lcd_power_ok  <= req_lcd_power_ok;
      end
   end

   otp_regs u_regs (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .item  (item_ff),
      .cfg   (cfg_ff),
      .rdata (rdata)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_rdata_ff <= rdata;
      end
   end

`ifndef SYNTHESIS
   // A beat in the item register that cannot move on is kept.
   assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && !advance |=> item_valid_ff)
      else $error("item register lost a beat while stalled");

   // Every beat that leaves the item register shows up as a result.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("result missing after item advanced");

   // Only reads return nonzero data.
   assert property (@(posedge clock) disable iff (reset)
      advance && (item_ff.req_type != otp_pkg::REQ_READ) |=> rsp_rdata == 8'h00)
      else $error("nonzero read data for a write or tick");

   // Input is refused only while a beat is held back by the result side.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> item_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("request refused without a stall");
`endif

endmodule
